[hw/rtl/rrwlm_pkg.sv]
// shared constants and codes for the recursive reader/writer lock manager
`timescale 1ns / 1ps

package rrwlm_pkg;

  // fixed field widths of the request and result words
  localparam int ActionW = 2;
  localparam int ReqIdW  = 4;
  localparam int StatusW = 3;
  localparam int CountW  = 5;

  // default sizing
  localparam int DefRequesters = 16;
  localparam int DefDepthBits  = 16;

  typedef enum logic [ActionW-1:0] {
    ActExclLock   = 2'd0,
    ActSharedLock = 2'd1,
    ActExclUnlock = 2'd2,
    ActSharedUnlk = 2'd3
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StsDone     = 3'd0,
    StsWait     = 3'd1,
    StsNotOwner = 3'd2,
    StsDeadlock = 3'd3,
    StsOverflow = 3'd4
  } status_e;

endpackage

[hw/rtl/rrwlm_rdmem.sv]
// per-requester shared depth memory, registered read, valid bits for reset
`timescale 1ns / 1ps

module rrwlm_rdmem #(
  parameter int ENTRIES    = 16,
  parameter int DEPTH_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output logic [DEPTH_BITS-1:0]      rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  logic [DEPTH_BITS-1:0]      wr_data_i
);

  logic [DEPTH_BITS-1:0] mem_q [ENTRIES];
  logic [ENTRIES-1:0]    vld_q;
  logic [DEPTH_BITS-1:0] rd_data_q;
  logic                  rd_vld_q;

  // storage itself, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // entry valid bits, an invalid entry reads as zero depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

[hw/rtl/recursive_rw_lock_manager_core.sv]
// top level of the recursive reader/writer lock manager
`timescale 1ns / 1ps

// Recursive reader/writer lock manager with writer preference. A request word
// (action, requester) is taken when start is high and busy is low. In the
// accept cycle the requester's shared depth is read from the depth memory,
// whose read is registered; in the next cycle the request is decided, the
// entry written back and the result registered. The result word appears in
// the cycle after on the result ports with strobe_o high for exactly one
// cycle; the receiver cannot stall it, so it must take the word in that cycle.
// busy is high only during the decide cycle, so a new request can be accepted
// in the same cycle that the previous result is shown. The depth memory needs
// no clearing pass after reset: per-entry valid bits make a fresh entry read
// as zero. A wait status means the requester retries the same request later.
module recursive_rw_lock_manager_core #(
  parameter int REQUESTERS = rrwlm_pkg::DefRequesters,
  parameter int DEPTH_BITS = rrwlm_pkg::DefDepthBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rrwlm_pkg::ActionW-1:0] action_i,
  input  logic [rrwlm_pkg::ReqIdW-1:0]  requester_i,
  output logic                          strobe_o,
  output logic [rrwlm_pkg::StatusW-1:0] status_o,
  output logic                          writer_held_o,
  output logic [rrwlm_pkg::CountW-1:0]  readers_now_o,
  output logic [rrwlm_pkg::CountW-1:0]  writers_waiting_o
);

  import rrwlm_pkg::*;

  localparam int IdxW = $clog2(REQUESTERS);
  localparam int CntW = $clog2(REQUESTERS + 1);
  localparam logic [DEPTH_BITS-1:0] DepthMax = '1;
  localparam logic [DEPTH_BITS-1:0] DepthOne = DEPTH_BITS'(1);

  // sequencer: idle (accepting) or deciding
  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;

  // captured request word
  logic [ActionW-1:0] act_q;
  logic [ReqIdW-1:0]  req_q;

  // writer owner
  logic [ReqIdW-1:0]     own_id_q, own_id_d;
  logic                  own_vld_q, own_vld_d;
  logic                  own_drain_q, own_drain_d;
  logic [DEPTH_BITS-1:0] own_depth_q, own_depth_d;

  // waiting writers and reader count
  logic [REQUESTERS-1:0] wait_q, wait_d;
  logic [CntW-1:0]       wtot_q, wtot_d;
  logic [CntW-1:0]       rtot_q, rtot_d;

  // result word
  logic               strobe_q;
  logic [StatusW-1:0] status_q;
  logic               held_q;
  logic [CountW-1:0]  readers_q;
  logic [CountW-1:0]  waiting_q;

  // depth memory access
  logic                  accept;
  logic [IdxW-1:0]       idx;
  logic [DEPTH_BITS-1:0] rdep;
  logic                  mem_we;
  logic [DEPTH_BITS-1:0] mem_wdata;

  logic    in_range;
  logic    is_owner;
  logic    wflag;
  status_e sts;

  assign busy   = (state_q == StExec);
  assign accept = start && !busy;
  assign idx    = IdxW'(req_q);

  rrwlm_rdmem #(
    .ENTRIES    (REQUESTERS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_rdmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (IdxW'(requester_i)),
    .rd_data_o (rdep),
    .wr_en_i   (mem_we),
    .wr_addr_i (idx),
    .wr_data_i (mem_wdata)
  );

  // request classification
  assign in_range = (32'(req_q) < 32'(REQUESTERS));
  assign is_owner = own_vld_q && (own_id_q == req_q);
  assign wflag    = in_range && wait_q[idx];

  // decide logic, mirrors the lock rules one request at a time
  always_comb begin
    state_d     = state_q;
    own_id_d    = own_id_q;
    own_vld_d   = own_vld_q;
    own_drain_d = own_drain_q;
    own_depth_d = own_depth_q;
    wait_d      = wait_q;
    wtot_d      = wtot_q;
    rtot_d      = rtot_q;
    mem_we      = 1'b0;
    mem_wdata   = rdep;
    sts         = StsDone;

    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StIdle;
        if (!in_range) begin
          sts = StsNotOwner;
        end else begin
          case (action_e'(act_q))
            ActExclLock: begin
              if (is_owner && !own_drain_q) begin
                // owner nests
                if (own_depth_q == DepthMax) begin
                  sts = StsOverflow;
                end else begin
                  own_depth_d = own_depth_q + DepthOne;
                end
              end else if (is_owner) begin
                // draining owner retries
                if (rtot_q != '0) begin
                  sts = StsWait;
                end else begin
                  own_drain_d = 1'b0;
                  if (wflag) begin
                    wait_d[idx] = 1'b0;
                    wtot_d      = wtot_q - CntW'(1);
                  end
                end
              end else if (rdep != '0) begin
                sts = StsDeadlock;
              end else if (own_vld_q) begin
                // register as waiting writer
                if (!wflag) begin
                  wait_d[idx] = 1'b1;
                  wtot_d      = wtot_q + CntW'(1);
                end
                sts = StsWait;
              end else begin
                // take ownership at once
                own_id_d    = req_q;
                own_vld_d   = 1'b1;
                own_depth_d = DepthOne;
                if (rtot_q != '0) begin
                  own_drain_d = 1'b1;
                  sts         = StsWait;
                  if (!wflag) begin
                    wait_d[idx] = 1'b1;
                    wtot_d      = wtot_q + CntW'(1);
                  end
                end else begin
                  own_drain_d = 1'b0;
                  // flag cleared here if it was already set
                  if (wflag) begin
                    wait_d[idx] = 1'b0;
                    wtot_d      = wtot_q - CntW'(1);
                  end
                end
              end
            end
            ActSharedLock: begin
              if (is_owner) begin
                if (own_drain_q) begin
                  sts = StsNotOwner;
                end else if (own_depth_q == DepthMax) begin
                  sts = StsOverflow;
                end else begin
                  own_depth_d = own_depth_q + DepthOne;
                end
              end else if (rdep != '0) begin
                // reader nests
                if (rdep == DepthMax) begin
                  sts = StsOverflow;
                end else begin
                  mem_we    = 1'b1;
                  mem_wdata = rdep + DepthOne;
                end
              end else if (wflag) begin
                sts = StsNotOwner;
              end else if ((wtot_q != '0) || own_vld_q) begin
                // writers have priority
                sts = StsWait;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = DepthOne;
                rtot_d    = rtot_q + CntW'(1);
              end
            end
            ActExclUnlock: begin
              if (!is_owner || own_drain_q) begin
                sts = StsNotOwner;
              end else if (own_depth_q > DepthOne) begin
                own_depth_d = own_depth_q - DepthOne;
              end else begin
                own_vld_d   = 1'b0;
                own_drain_d = 1'b0;
                own_depth_d = DepthOne;
              end
            end
            ActSharedUnlk: begin
              if (is_owner) begin
                // owner's shared unlock drops its exclusive depth
                if (own_drain_q) begin
                  sts = StsNotOwner;
                end else if (own_depth_q > DepthOne) begin
                  own_depth_d = own_depth_q - DepthOne;
                end else begin
                  own_vld_d   = 1'b0;
                  own_drain_d = 1'b0;
                  own_depth_d = DepthOne;
                end
              end else if (rdep == '0) begin
                sts = StsNotOwner;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = rdep - DepthOne;
                if (rdep == DepthOne) begin
                  rtot_d = rtot_q - CntW'(1);
                end
              end
            end
            default: begin
              sts = StsNotOwner;
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // captured request, payload only
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      req_q <= requester_i;
    end
  end

  // lock state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      own_id_q    <= '0;
      own_vld_q   <= 1'b0;
      own_drain_q <= 1'b0;
      own_depth_q <= DepthOne;
      wait_q      <= '0;
      wtot_q      <= '0;
      rtot_q      <= '0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      own_id_q    <= own_id_d;
      own_vld_q   <= own_vld_d;
      own_drain_q <= own_drain_d;
      own_depth_q <= own_depth_d;
      wait_q      <= wait_d;
      wtot_q      <= wtot_d;
      rtot_q      <= rtot_d;
      strobe_q    <= (state_q == StExec);
    end
  end

  // result word, snapshot after the request
  always_ff @(posedge clk_i) begin
    if (state_q == StExec) begin
      status_q  <= sts;
      held_q    <= own_vld_d;
      readers_q <= CountW'(rtot_d);
      waiting_q <= CountW'(wtot_d);
    end
  end

  assign strobe_o          = strobe_q;
  assign status_o          = status_q;
  assign writer_held_o     = held_q;
  assign readers_now_o     = readers_q;
  assign writers_waiting_o = waiting_q;

endmodule

[bench/recursive_rw_lock_manager_core_tb.sv]
// testbench for recursive_rw_lock_manager_core: directed table, depth walks, random traffic
`timescale 1ns / 1ps

// Each request word is driven at a rising edge. It counts as taken at the first
// later edge at which start is high and busy was low just before that edge.
// Taken words run through a local lock state model in order. The model's view
// of the lock after each word goes into a queue, and each strobed result word
// is compared with the head of that queue. Stimulus comes in three parts:
//  - a short directed table from reset: errors, draining, writer preference,
//    deadlock and nesting, some rows with their result typed in
//  - short depth walks for both the exclusive owner and a plain reader,
//    nesting a few levels and then back down
//  - random traffic built from retries and well-formed lock/unlock pairs,
//    mixed with some raw noise
module recursive_rw_lock_manager_core_tb;
  import rrwlm_pkg::*;

  localparam int ClkHalf    = 10;
  localparam int NumIds     = DefRequesters;
  localparam int DepthBits  = DefDepthBits;
  localparam int RandWords  = 940;
  localparam int WalkDepth  = 8;
  localparam int DrainLimit = 1000;
  localparam logic [DepthBits-1:0] DepthMax = '1;

  // lock state as seen on the result ports
  typedef struct packed {
    status_e            status;
    logic               held;
    logic [CountW-1:0]  readers;
    logic [CountW-1:0]  waiters;
  } lock_view_t;

  // one row of the directed table; pinned rows carry a typed-in result
  typedef struct {
    action_e     act;
    logic [3:0]  req;
    bit          pinned;
    lock_view_t  view;
  } table_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [ActionW-1:0]  action_i;
  logic [ReqIdW-1:0]   requester_i;
  logic                strobe_o;
  logic [StatusW-1:0]  status_o;
  logic                writer_held_o;
  logic [CountW-1:0]   readers_now_o;
  logic [CountW-1:0]   writers_waiting_o;

  recursive_rw_lock_manager_core uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .action_i          (action_i),
    .requester_i       (requester_i),
    .strobe_o          (strobe_o),
    .status_o          (status_o),
    .writer_held_o     (writer_held_o),
    .readers_now_o     (readers_now_o),
    .writers_waiting_o (writers_waiting_o)
  );

  // local copy of the lock state
  logic [3:0]            own_id;
  bit                    own_valid;
  bit                    own_drain;
  logic [DepthBits-1:0]  own_depth;
  bit                    wait_flag [NumIds];
  int                    wait_cnt;
  logic [DepthBits-1:0]  rd_depth [NumIds];
  int                    rd_cnt;

  lock_view_t  lock_view_q[$];
  table_row_t  table_q[$];
  int          mismatch_count;

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  task automatic report_mismatch(string what);
    if (mismatch_count < 50) $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void clear_wait(logic [3:0] r);
    if (wait_flag[r]) begin
      wait_flag[r] = 1'b0;
      wait_cnt--;
    end
  endfunction

  // one request against the local lock state, returns the status word
  function automatic status_e apply_request(action_e act, logic [3:0] r);
    bit is_own;
    is_own = own_valid && (own_id == r);
    case (act)
      ActExclLock: begin
        if (is_own && !own_drain) begin
          if (own_depth == DepthMax) return StsOverflow;
          own_depth++;
          return StsDone;
        end
        // draining owner retrying: done once the last reader has left
        if (is_own) begin
          if (rd_cnt != 0) return StsWait;
          own_drain = 1'b0;
          clear_wait(r);
          return StsDone;
        end
        if (rd_depth[r] != 0) return StsDeadlock;
        if (!wait_flag[r]) begin
          wait_flag[r] = 1'b1;
          wait_cnt++;
        end
        if (own_valid) return StsWait;
        // free lock: ownership at once, draining while readers remain
        own_id    = r;
        own_valid = 1'b1;
        own_depth = 1;
        if (rd_cnt != 0) begin
          own_drain = 1'b1;
          return StsWait;
        end
        own_drain = 1'b0;
        clear_wait(r);
        return StsDone;
      end
      ActSharedLock: begin
        if (is_own) begin
          if (own_drain) return StsNotOwner;
          if (own_depth == DepthMax) return StsOverflow;
          own_depth++;
          return StsDone;
        end
        if (rd_depth[r] != 0) begin
          if (rd_depth[r] == DepthMax) return StsOverflow;
          rd_depth[r]++;
          return StsDone;
        end
        if (wait_flag[r]) return StsNotOwner;
        // writer preference: new readers hold off while any writer is around
        if (wait_cnt != 0 || own_valid) return StsWait;
        rd_depth[r] = 1;
        rd_cnt++;
        return StsDone;
      end
      ActExclUnlock: begin
        if (!is_own || own_drain) return StsNotOwner;
        if (own_depth > 1) own_depth--;
        else begin
          own_valid = 1'b0;
          own_depth = 1;
        end
        return StsDone;
      end
      default: begin
        // the owner's shared unlock drops its exclusive depth too
        if (is_own) begin
          if (own_drain) return StsNotOwner;
          if (own_depth > 1) own_depth--;
          else begin
            own_valid = 1'b0;
            own_depth = 1;
          end
          return StsDone;
        end
        if (rd_depth[r] == 0) return StsNotOwner;
        rd_depth[r]--;
        if (rd_depth[r] == 0) rd_cnt--;
        return StsDone;
      end
    endcase
  endfunction

  function automatic lock_view_t predict_view(action_e act, logic [3:0] r);
    lock_view_t v;
    v.status  = apply_request(act, r);
    v.held    = own_valid;
    v.readers = CountW'(rd_cnt);
    v.waiters = CountW'(wait_cnt);
    return v;
  endfunction

  // drive one word and hold it until taken; returns the predicted view
  task automatic issue(action_e act, logic [3:0] r, output lock_view_t v);
    action_i    <= act;
    requester_i <= r;
    start       <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    v = predict_view(act, r);
  endtask

  task automatic issue_checked(action_e act, logic [3:0] r);
    lock_view_t v;
    issue(act, r, v);
    lock_view_q.push_back(v);
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic idle_gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic add_row(action_e act, logic [3:0] r, bit pinned, status_e st,
                         logic held, int rd, int wt);
    table_row_t row;
    row.act          = act;
    row.req          = r;
    row.pinned       = pinned;
    row.view.status  = st;
    row.view.held    = held;
    row.view.readers = CountW'(rd);
    row.view.waiters = CountW'(wt);
    table_q.push_back(row);
  endtask

  // random word shaped by the current lock state: retries, nest/unlock pairs
  task automatic pick_word(output action_e act, output logic [3:0] r);
    int roll;
    r    = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      act = action_e'($urandom_range(0, 3));
    end else if (wait_flag[r] || (own_valid && own_id == r && own_drain)) begin
      act = ActExclLock;
    end else if (own_valid && own_id == r) begin
      case ($urandom_range(0, 9))
        0, 1:    act = ActExclLock;
        2, 3:    act = ActSharedLock;
        4, 5, 6: act = ActExclUnlock;
        default: act = ActSharedUnlk;
      endcase
    end else if (rd_depth[r] != 0) begin
      if (roll < 50)      act = ActSharedLock;
      else if (roll < 92) act = ActSharedUnlk;
      else                act = ActExclLock;
    end else begin
      act = (roll < 56) ? ActSharedLock : ActExclLock;
    end
  endtask

  // result side: every strobed word against the oldest expectation
  always @(posedge clk_i) begin
    lock_view_t want;
    if (rst_ni && strobe_o) begin
      if (lock_view_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = lock_view_q.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (writer_held_o !== want.held)
          report_mismatch($sformatf("writer_held %0d, expected %0d",
                                    writer_held_o, want.held));
        if (readers_now_o !== want.readers)
          report_mismatch($sformatf("readers_now %0d, expected %0d",
                                    readers_now_o, want.readers));
        if (writers_waiting_o !== want.waiters)
          report_mismatch($sformatf("writers_waiting %0d, expected %0d",
                                    writers_waiting_o, want.waiters));
      end
    end
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("recursive_rw_lock_manager_core test failed");
    $finish;
  end

  initial begin
    lock_view_t  v;
    table_row_t  row;
    action_e     act;
    logic [3:0]  r;
    bit          eager;
    int          settle;

    rst_ni         = 1'b0;
    start          = 1'b0;
    action_i       = '0;
    requester_i    = '0;
    mismatch_count = 0;
    own_id         = '0;
    own_valid      = 1'b0;
    own_drain      = 1'b0;
    own_depth      = 1;
    wait_cnt       = 0;
    rd_cnt         = 0;
    for (int i = 0; i < NumIds; i++) begin
      wait_flag[i] = 1'b0;
      rd_depth[i]  = '0;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: unlocks without a hold, readers, a writer draining them,
    // a second writer waiting, blocked readers, the drain finishing, nesting
    add_row(ActExclUnlock, 4'd0,  1, StsNotOwner, 0, 0, 0);
    add_row(ActSharedUnlk, 4'd15, 1, StsNotOwner, 0, 0, 0);
    add_row(ActSharedLock, 4'd3,  1, StsDone,     0, 1, 0);
    add_row(ActSharedLock, 4'd3,  0, StsDone,     0, 0, 0);
    add_row(ActExclLock,   4'd3,  1, StsDeadlock, 0, 1, 0);
    add_row(ActSharedLock, 4'd15, 0, StsDone,     0, 0, 0);
    add_row(ActExclLock,   4'd0,  1, StsWait,     1, 2, 1);
    add_row(ActSharedLock, 4'd0,  1, StsNotOwner, 1, 2, 1);
    add_row(ActExclUnlock, 4'd0,  1, StsNotOwner, 1, 2, 1);
    add_row(ActSharedUnlk, 4'd0,  1, StsNotOwner, 1, 2, 1);
    add_row(ActExclLock,   4'd5,  1, StsWait,     1, 2, 2);
    add_row(ActSharedLock, 4'd5,  1, StsNotOwner, 1, 2, 2);
    add_row(ActSharedLock, 4'd7,  0, StsDone,     0, 0, 0);
    add_row(ActSharedLock, 4'd3,  0, StsDone,     0, 0, 0);
    add_row(ActSharedUnlk, 4'd15, 0, StsDone,     0, 0, 0);
    for (int i = 0; i < 3; i++) add_row(ActSharedUnlk, 4'd3, 0, StsDone, 0, 0, 0);
    add_row(ActExclLock,   4'd0,  1, StsDone,     1, 0, 1);
    add_row(ActSharedLock, 4'd0,  0, StsDone,     0, 0, 0);
    add_row(ActExclLock,   4'd0,  0, StsDone,     0, 0, 0);
    add_row(ActSharedUnlk, 4'd0,  0, StsDone,     0, 0, 0);
    add_row(ActExclUnlock, 4'd0,  0, StsDone,     0, 0, 0);
    add_row(ActExclUnlock, 4'd0,  1, StsDone,     0, 0, 1);
    add_row(ActExclLock,   4'd5,  1, StsDone,     1, 0, 0);
    add_row(ActExclUnlock, 4'd5,  1, StsDone,     0, 0, 0);

    foreach (table_q[i]) begin
      row = table_q[i];
      issue(row.act, row.req, v);
      lock_view_q.push_back(row.pinned ? row.view : v);
      idle_gap(pick_gap());
    end

    // owner depth walk: nest with both lock kinds, then unwind
    issue_checked(ActExclLock, 4'd9);
    for (int i = 1; i < WalkDepth; i++)
      issue_checked(i[0] ? ActExclLock : ActSharedLock, 4'd9);
    for (int i = 0; i < WalkDepth; i++)
      issue_checked(i[0] ? ActSharedUnlk : ActExclUnlock, 4'd9);

    // reader depth walk on its own entry, deadlock check, unwind
    for (int i = 0; i < WalkDepth; i++) issue_checked(ActSharedLock, 4'd12);
    issue_checked(ActExclLock, 4'd12);
    for (int i = 0; i < WalkDepth; i++) issue_checked(ActSharedUnlk, 4'd12);
    idle_gap(pick_gap());

    // random traffic, with stretches where no gaps are inserted
    eager = 1'b0;
    for (int n = 0; n < RandWords; n++) begin
      if (n % 100 == 0) eager = ($urandom_range(0, 3) == 0);
      pick_word(act, r);
      issue_checked(act, r);
      if (!eager) idle_gap(pick_gap());
    end

    // drain: wait for the last result word, then watch for strays
    start  <= 1'b0;
    settle = 0;
    while (lock_view_q.size() != 0 && settle < DrainLimit) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (4) @(posedge clk_i);
    if (lock_view_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", lock_view_q.size()));

    if (mismatch_count == 0) begin
      $display("recursive_rw_lock_manager_core test passed");
    end else begin
      $display("recursive_rw_lock_manager_core test failed");
    end
    $finish;
  end

endmodule
